FILE: design/ofdrw_pkg.sv
// ----------------------------------------------------------------------------
// Output divider register writer package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ofdrw_pkg;

    localparam logic [29:0] VCO_RESET  = 30'd700000000;
    localparam logic [31:0] DIV_MIN    = 32'd4;
    localparam logic [31:0] DIV_MAX    = 32'd2048;
    localparam logic [7:0]  CTRL_BYTE  = 8'h0F;
    localparam logic [7:0]  RESET_BYTE = 8'hA0;
    localparam logic [7:0]  ADDR_PHASE0 = 8'd165;
    localparam logic [7:0]  ADDR_PHASE1 = 8'd166;
    localparam logic [7:0]  ADDR_RESET  = 8'd177;
    localparam logic [7:0]  ADDR_MS0    = 8'd42;
    localparam logic [7:0]  ADDR_CTRL0  = 8'd16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Datapath operations requested by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_DIV   = 3'd2,
        OP_GCD   = 3'd3,
        OP_SCALE = 3'd4,
        OP_Q     = 3'd5,
        OP_PWORD = 3'd6
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic zero_freq;
        logic out_range;
        logic over_limit;
    } dp_status_t;

endpackage

FILE: design/ofdrw_datapath.sv
// ----------------------------------------------------------------------------
// Output divider register writer datapath
// Holds the operands, a shared restoring divider, the gcd unit and the
// fractional divider words, and builds the register write for an index.
// ----------------------------------------------------------------------------
module ofdrw_datapath #(
    parameter int unsigned DENOM_LIMIT = 65535
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [29:0]          vco,
    input  logic [31:0]          freq_in,
    input  ofdrw_pkg::dp_cmd_t   cmd,
    input  logic [4:0]           wr_index,
    input  logic                 range_only,
    output ofdrw_pkg::dp_status_t stat,
    output logic                 busy,
    output logic [7:0]           wr_addr,
    output logic [7:0]           wr_data
);

    // Shared divider: dividend up to 52 bits, divisor 32 bits.
    localparam int DW = 52;

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [31:0] freq_reg, freq_next;
    logic [31:0] div_reg, div_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] ga_reg, ga_next;
    logic [31:0] gb_reg, gb_next;
    logic [1:0]  gph_reg, gph_next;
    logic [17:0] p1_reg, p1_next;
    logic [19:0] p2_reg, p2_next;
    logic [51:0] prod_reg, prod_next;
    logic        pph_reg, pph_next;
    logic [29:0] vco_reg, vco_next;

    logic [32:0] trial;
    logic [32:0] shifted;
    logic [31:0] phase_div;

    assign shifted = {rem_reg[31:0], dvd_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        freq_reg <= freq_next;
        div_reg <= div_next;
        num_reg <= num_next;
        den_reg <= den_next;
        ga_reg <= ga_next;
        gb_reg <= gb_next;
        gph_reg <= gph_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        prod_reg <= prod_next;
        pph_reg <= pph_next;
        vco_reg <= vco_next;
    end

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        freq_next = freq_reg;
        div_next = div_reg;
        num_next = num_reg;
        den_next = den_reg;
        ga_next = ga_reg;
        gb_next = gb_reg;
        gph_next = gph_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        prod_next = prod_reg;
        pph_next = pph_reg;
        vco_next = vco_reg;

        if (busy_reg) begin
            if (trial[32]) begin
                rem_next = shifted;
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
            end else begin
                rem_next = trial;
                dvd_next = {dvd_reg[DW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end

        if (cmd.start) begin
            case (cmd.op)
                ofdrw_pkg::OP_LOAD: begin
                    freq_next = freq_in;
                    vco_next = vco;
                    done_next = 1'b1;
                end
                ofdrw_pkg::OP_DIV: begin
                    dvd_next = {vco_reg, 22'd0};
                    dvs_next = freq_reg;
                    rem_next = '0;
                    cnt_next = 6'd30;
                    busy_next = 1'b1;
                    gph_next = 2'd0;
                end
                ofdrw_pkg::OP_GCD: begin
                    if (gph_reg == 2'd0) begin
                        div_next = dvd_reg[31:0];
                        num_next = rem_reg[31:0];
                        den_next = freq_reg;
                        ga_next = rem_reg[31:0];
                        gb_next = freq_reg;
                        gph_next = 2'd1;
                    end else if (gph_reg == 2'd1) begin
                        if (ga_reg == 32'd0) begin
                            dvd_next = {num_reg, 20'd0};
                            dvs_next = gb_reg;
                            rem_next = '0;
                            cnt_next = 6'd32;
                            busy_next = 1'b1;
                            gph_next = 2'd2;
                        end else begin
                            dvd_next = {gb_reg, 20'd0};
                            dvs_next = ga_reg;
                            rem_next = '0;
                            cnt_next = 6'd32;
                            busy_next = 1'b1;
                            gph_next = 2'd3;
                        end
                    end else if (gph_reg == 2'd3) begin
                        gb_next = ga_reg;
                        ga_next = rem_reg[31:0];
                        gph_next = 2'd1;
                    end else begin
                        if (pph_reg == 1'b0) begin
                            num_next = dvd_reg[31:0];
                            dvd_next = {den_reg, 20'd0};
                            dvs_next = gb_reg;
                            rem_next = '0;
                            cnt_next = 6'd32;
                            busy_next = 1'b1;
                            pph_next = 1'b1;
                        end else begin
                            den_next = dvd_reg[31:0];
                            pph_next = 1'b0;
                            done_next = 1'b1;
                            gph_next = 2'd0;
                        end
                    end
                end
                ofdrw_pkg::OP_SCALE: begin
                    if (pph_reg == 1'b0) begin
                        prod_next = num_reg * 52'(DENOM_LIMIT);
                        pph_next = 1'b1;
                    end else begin
                        dvd_next = prod_reg;
                        dvs_next = den_reg;
                        rem_next = '0;
                        cnt_next = 6'(DW);
                        busy_next = 1'b1;
                        pph_next = 1'b0;
                        gph_next = 2'd2;
                        den_next = 32'(DENOM_LIMIT);
                    end
                end
                ofdrw_pkg::OP_Q: begin
                    if (pph_reg == 1'b0) begin
                        if (gph_reg == 2'd2) begin
                            num_next = dvd_reg[31:0];
                        end
                        gph_next = 2'd0;
                        pph_next = 1'b1;
                    end else begin
                        dvd_next = {num_reg[19:0], 7'd0, 25'd0};
                        dvs_next = den_reg;
                        rem_next = '0;
                        cnt_next = 6'd27;
                        busy_next = 1'b1;
                        pph_next = 1'b0;
                    end
                end
                ofdrw_pkg::OP_PWORD: begin
                    p1_next = 18'({div_reg[11:0], 7'd0} + {11'd0, dvd_reg[7:0]} - 19'd512);
                    p2_next = rem_reg[19:0];
                    done_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign phase_div = div_reg;
    assign busy = busy_reg;

    always_comb begin
        stat.done = done_reg;
        stat.zero_freq = (freq_reg == 32'd0);
        stat.out_range = (div_reg < ofdrw_pkg::DIV_MIN) || (div_reg > ofdrw_pkg::DIV_MAX);
        stat.over_limit = (den_reg > 32'(DENOM_LIMIT)) && !busy_reg;
    end

    always_comb begin
        wr_addr = 8'd0;
        wr_data = 8'd0;
        if (range_only || wr_index >= 5'd18) begin
            case (wr_index)
                5'd18: begin
                    wr_addr = ofdrw_pkg::ADDR_PHASE0;
                    wr_data = 8'd0;
                end
                5'd19: begin
                    wr_addr = ofdrw_pkg::ADDR_PHASE1;
                    wr_data = {1'b0, phase_div[6:0]};
                end
                default: begin
                    wr_addr = ofdrw_pkg::ADDR_RESET;
                    wr_data = ofdrw_pkg::RESET_BYTE;
                end
            endcase
        end else begin
            case (wr_index)
                5'd0, 5'd9: wr_data = den_reg[15:8];
                5'd1, 5'd10: wr_data = den_reg[7:0];
                5'd2, 5'd11: wr_data = {6'd0, p1_reg[17:16]};
                5'd3, 5'd12: wr_data = p1_reg[15:8];
                5'd4, 5'd13: wr_data = p1_reg[7:0];
                5'd5, 5'd14: wr_data = {den_reg[19:16], p2_reg[19:16]};
                5'd6, 5'd15: wr_data = p2_reg[15:8];
                5'd7, 5'd16: wr_data = p2_reg[7:0];
                default: wr_data = ofdrw_pkg::CTRL_BYTE;
            endcase
            if (wr_index == 5'd8) begin
                wr_addr = ofdrw_pkg::ADDR_CTRL0;
            end else if (wr_index == 5'd17) begin
                wr_addr = ofdrw_pkg::ADDR_CTRL0 + 8'd1;
            end else if (wr_index < 5'd8) begin
                wr_addr = ofdrw_pkg::ADDR_MS0 + {3'd0, wr_index};
            end else begin
                wr_addr = ofdrw_pkg::ADDR_MS0 + {3'd0, wr_index} - 8'd1;
            end
        end
    end

endmodule

FILE: design/ofdrw_ctrl.sv
// ----------------------------------------------------------------------------
// Output divider register writer controller
// Sequences the datapath operations and the register write transactions.
// ----------------------------------------------------------------------------
module ofdrw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_last_write,
    output logic [1:0]            m_status,
    output ofdrw_pkg::dp_cmd_t    cmd,
    input  ofdrw_pkg::dp_status_t stat,
    input  logic                  busy,
    output logic [4:0]            wr_index,
    output logic                  range_only
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LOAD  = 8'b00000010,
        S_DIV   = 8'b00000100,
        S_GCD   = 8'b00001000,
        S_SCALE = 8'b00010000,
        S_Q     = 8'b00100000,
        S_PWORD = 8'b01000000,
        S_EMIT  = 8'b10000000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  idx_reg, idx_next;
    logic [1:0]  st_reg, st_next;
    logic [1:0]  sub_reg, sub_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg <= 5'd0;
            st_reg <= ofdrw_pkg::ST_OK;
            sub_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            st_reg <= st_next;
            sub_reg <= sub_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        st_next = st_reg;
        sub_next = sub_reg;
        cmd.start = 1'b0;
        cmd.op = ofdrw_pkg::OP_NONE;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_EMIT);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    cmd.op = ofdrw_pkg::OP_LOAD;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (stat.zero_freq) begin
                    st_next = ofdrw_pkg::ST_ZERO;
                    idx_next = 5'd20;
                    state_next = S_EMIT;
                end else begin
                    cmd.start = 1'b1;
                    cmd.op = ofdrw_pkg::OP_DIV;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!busy) begin
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (!busy) begin
                    cmd.start = 1'b1;
                    cmd.op = ofdrw_pkg::OP_GCD;
                    if (stat.done) begin
                        cmd.start = 1'b0;
                        sub_next = 2'd0;
                        if (stat.out_range) begin
                            st_next = ofdrw_pkg::ST_RANGE;
                            idx_next = 5'd18;
                            state_next = S_EMIT;
                        end else if (stat.over_limit) begin
                            state_next = S_SCALE;
                        end else begin
                            state_next = S_Q;
                        end
                    end
                end
            end
            S_SCALE: begin
                if (!busy) begin
                    if (sub_reg == 2'd2) begin
                        sub_next = 2'd0;
                        state_next = S_Q;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.op = ofdrw_pkg::OP_SCALE;
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            S_Q: begin
                if (!busy) begin
                    if (sub_reg == 2'd2) begin
                        sub_next = 2'd0;
                        state_next = S_PWORD;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.op = ofdrw_pkg::OP_Q;
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            S_PWORD: begin
                if (!busy) begin
                    if (stat.done) begin
                        st_next = ofdrw_pkg::ST_OK;
                        idx_next = 5'd0;
                        state_next = S_EMIT;
                    end else if (sub_reg == 2'd0) begin
                        cmd.start = 1'b1;
                        cmd.op = ofdrw_pkg::OP_PWORD;
                        sub_next = 2'd1;
                    end
                end
            end
            S_EMIT: begin
                sub_next = 2'd0;
                if (m_ready) begin
                    if (idx_reg == 5'd20) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign wr_index = idx_reg;
    assign range_only = (st_reg != ofdrw_pkg::ST_OK);
    assign m_last_write = (idx_reg == 5'd20);
    assign m_status = st_reg;

endmodule

FILE: design/output_freq_divider_register_writer_unit.sv
// ----------------------------------------------------------------------------
// Output divider register writer
// Turns a target output frequency into the fractional divider register
// writes for outputs 0 and 1, then the phase and reset writes.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// s       | in        | s_valid, s_ready, s_target_freq
// m       | out       | m_valid, m_ready, m_reg_address, m_reg_data, m_last_write, m_status
// cfg     | in        | cfg_we, cfg_wdata (vco_freq)
//
// A zero frequency gives a single write; a divider out of range gives the 3 phase
// and reset writes only, and any other transaction gives 21 writes.
// The time is set by the single shared bit-serial divider, one quotient bit a
// cycle, which serves the divide, each gcd step, the scaling and the fractional word.
// Reset is synchronous and returns vco_freq to 700000000.
// Output stalls hold the current write; no new input is taken until the last.
// ----------------------------------------------------------------------------
module output_freq_divider_register_writer_unit #(
    parameter int unsigned DENOM_LIMIT = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [29:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_target_freq,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_reg_address,
    output logic [7:0]  m_reg_data,
    output logic        m_last_write,
    output logic [1:0]  m_status
);

    logic [29:0]           vco_reg;
    ofdrw_pkg::dp_cmd_t    cmd;
    ofdrw_pkg::dp_status_t stat;
    logic [4:0]            wr_index;
    logic                  range_only;
    logic                  busy;
    logic [7:0]            addr;
    logic [7:0]            data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vco_reg <= ofdrw_pkg::VCO_RESET;
        end else if (cfg_we) begin
            vco_reg <= cfg_wdata;
        end
    end

    ofdrw_datapath #(.DENOM_LIMIT(DENOM_LIMIT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .vco(vco_reg), .freq_in(s_target_freq),
        .cmd(cmd), .wr_index(wr_index), .range_only(range_only), .stat(stat),
        .busy(busy), .wr_addr(addr), .wr_data(data)
    );

    ofdrw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_last_write(m_last_write),
        .m_status(m_status), .cmd(cmd), .stat(stat), .busy(busy),
        .wr_index(wr_index), .range_only(range_only)
    );

    assign m_reg_address = (m_status == ofdrw_pkg::ST_ZERO) ? 8'd0 : addr;
    assign m_reg_data    = (m_status == ofdrw_pkg::ST_ZERO) ? 8'd0 : data;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken during output");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_write) |=> !m_valid) else $error("run overran");
    a_zero_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ofdrw_pkg::ST_ZERO) |-> m_last_write)
        else $error("zero frequency run too long");

endmodule
